@@ design/tbr_pkg.sv @@
package tbr_pkg;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_WB    = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Steps of the shared multiplier, in issue order
  typedef enum logic [3:0] {
    OP_AA  = 4'd0,
    OP_AB  = 4'd1,
    OP_BB  = 4'd2,
    OP_AAA = 4'd3,
    OP_AAB = 4'd4,
    OP_ABB = 4'd5,
    OP_BBB = 4'd6,
    OP_P0  = 4'd7,
    OP_P1  = 4'd8,
    OP_P2  = 4'd9,
    OP_P3  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    CFG_CURVE_MODE  = 3'd0,
    CFG_TOTAL_TICKS = 3'd1,
    CFG_POINT_START = 3'd2,
    CFG_POINT_MID_A = 3'd3,
    CFG_POINT_MID_B = 3'd4,
    CFG_POINT_END   = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] CM_LINEAR = 2'd0;
  localparam logic [1:0] CM_QUAD   = 2'd1;

  localparam logic        KIND_RESTART = 1'b1;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/timed_bezier_ramp.sv @@
// Tick-driven Bezier ramp generator.
// Input channel (in_valid / in_stall) carries one beat per event: kind 0 is a
// tick, kind 1 a restart; frozen holds the ramp on a tick. Every input beat
// yields exactly one output beat (ramp_value, updated, done_res).
// A tick that advances the counter recomputes the value: an iterative
// divider forms the fraction one quotient bit per cycle, then one shared
// multiplier runs eleven steps, each a multiply and a write-back state
// (seven weight products, four point products). A tick whose fraction
// clamps to one skips the bit-by-bit divide. Restarts, frozen ticks and
// ticks after done go straight from idle to the output state.
// One item is in work at a time: in_stall stays high from acceptance until
// the result is placed in the output register. A result waiting on
// out_stall does not block the next input beat, but that item's result
// waits until the output register is taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// the user must make them only while idle, which the block does not enforce.
// Indexes past the register list are dropped. Reset (rst, synchronous) clears
// counter, done mark, held value, out_valid; total_ticks=1, other config=0.
module timed_bezier_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic               frozen,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ramp_value,
  output logic               updated,
  output logic               done_res
);
  import tbr_pkg::*;

  localparam int WW = FRAC_BITS + 3;
  localparam int PW = 33 + FRAC_BITS + 4;
  localparam int RW = 2 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0]  ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [RW-1:0]       HALF_W = RW'(1) << (FRAC_BITS - 1);
  localparam logic signed [63:0]  HALF_S = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0]  S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0]  S32_MIN = -64'sd2147483648;

  // configuration registers
  logic [1:0]         curve_mode;
  logic [15:0]        total_ticks;
  logic signed [31:0] point_start;
  logic signed [31:0] point_mid_a;
  logic signed [31:0] point_mid_b;
  logic signed [31:0] point_end;

  // block state
  state_t             state;
  logic [16:0]        elapsed_count;
  logic               finished;
  logic signed [31:0] held_value;
  logic               upd;
  op_t                op;

  // datapath
  logic [FRAC_BITS:0]   aa, ab, bb, c0, c1, c2, c3;
  logic signed [PW-1:0] prod;
  logic signed [63:0]   sum;

  logic                 in_acc;
  logic                 tick_go;
  logic [16:0]          elapsed_next;
  div_stat_t            div_stat;
  logic [FRAC_BITS:0]   b;
  logic [FRAC_BITS:0]   a;
  logic [WW-1:0]        w0, w1, w2, w3;
  logic signed [32:0]   mx;
  logic [WW-1:0]        my_u;
  logic signed [WW:0]   my;
  logic [RW-1:0]        rsum;
  logic [FRAC_BITS:0]   rnd_val;
  logic signed [63:0]   prod_ext;
  logic signed [63:0]   shifted;
  logic signed [31:0]   result;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign tick_go  = in_acc && (kind != KIND_RESTART) && !finished && !frozen;

  assign elapsed_next = (elapsed_count == ELAPSED_MAX) ? elapsed_count
                                                       : elapsed_count + 17'd1;

  tbr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (tick_go),
    .num   (elapsed_next),
    .den   (total_ticks),
    .stat  (div_stat),
    .quot  (b)
  );

  assign a = ONE - b;

  always_comb begin
    case (curve_mode)
      CM_LINEAR: begin
        w0 = {2'b00, a};
        w1 = '0;
        w2 = '0;
        w3 = {2'b00, b};
      end
      CM_QUAD: begin
        w0 = {2'b00, aa};
        w1 = {1'b0, ab, 1'b0};
        w2 = '0;
        w3 = {2'b00, bb};
      end
      default: begin
        w0 = {2'b00, c0};
        w1 = {2'b00, c1} + {1'b0, c1, 1'b0};
        w2 = {2'b00, c2} + {1'b0, c2, 1'b0};
        w3 = {2'b00, c3};
      end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mx   = '0;
    my_u = '0;
    case (op)
      OP_AA:  begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, a});  my_u = {2'b00, a}; end
      OP_AB:  begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, a});  my_u = {2'b00, b}; end
      OP_BB:  begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, b});  my_u = {2'b00, b}; end
      OP_AAA: begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, aa}); my_u = {2'b00, a}; end
      OP_AAB: begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, aa}); my_u = {2'b00, b}; end
      OP_ABB: begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, ab}); my_u = {2'b00, b}; end
      OP_BBB: begin mx = signed'({{(32 - FRAC_BITS){1'b0}}, bb}); my_u = {2'b00, b}; end
      OP_P0:  begin mx = {point_start[31], point_start}; my_u = w0; end
      OP_P1:  begin mx = {point_mid_a[31], point_mid_a}; my_u = w1; end
      OP_P2:  begin mx = {point_mid_b[31], point_mid_b}; my_u = w2; end
      OP_P3:  begin mx = {point_end[31], point_end};     my_u = w3; end
      default: begin mx = '0; my_u = '0; end
    endcase
  end

  assign my       = signed'({1'b0, my_u});
  assign rsum     = prod[RW-1:0] + HALF_W;
  assign rnd_val  = rsum[2*FRAC_BITS:FRAC_BITS];
  assign prod_ext = {{(64 - PW){prod[PW-1]}}, prod};
  assign shifted  = sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > S32_MAX) begin
      result = S32_MAX[31:0];
    end else if (shifted < S32_MIN) begin
      result = S32_MIN[31:0];
    end else begin
      result = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= CM_LINEAR;
      total_ticks <= 16'd1;
      point_start <= '0;
      point_mid_a <= '0;
      point_mid_b <= '0;
      point_end   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CURVE_MODE:  curve_mode  <= cfg_data[1:0];
        CFG_TOTAL_TICKS: total_ticks <= cfg_data[15:0];
        CFG_POINT_START: point_start <= signed'(cfg_data);
        CFG_POINT_MID_A: point_mid_a <= signed'(cfg_data);
        CFG_POINT_MID_B: point_mid_b <= signed'(cfg_data);
        CFG_POINT_END:   point_end   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      elapsed_count <= '0;
      finished      <= 1'b0;
      held_value    <= '0;
      upd           <= 1'b0;
      op            <= OP_AA;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (kind == KIND_RESTART) begin
              elapsed_count <= '0;
              finished      <= 1'b0;
              upd           <= 1'b0;
              state         <= ST_OUT;
            end else if (tick_go) begin
              elapsed_count <= elapsed_next;
              finished      <= elapsed_next > {1'b0, total_ticks};
              upd           <= 1'b1;
              state         <= ST_DIV;
            end else begin
              upd   <= 1'b0;
              state <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            op    <= OP_AA;
            sum   <= HALF_S;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mx * my;
          state <= ST_WB;
        end
        ST_WB: begin
          case (op)
            OP_AA:  aa <= rnd_val;
            OP_AB:  ab <= rnd_val;
            OP_BB:  bb <= rnd_val;
            OP_AAA: c0 <= rnd_val;
            OP_AAB: c1 <= rnd_val;
            OP_ABB: c2 <= rnd_val;
            OP_BBB: c3 <= rnd_val;
            default: sum <= sum + prod_ext;
          endcase
          if (op == OP_P3) begin
            state <= ST_FINAL;
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= ST_MUL;
          end
        end
        ST_FINAL: begin
          held_value <= result;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          // load only once the previous beat has left
          if (!out_valid || !out_stall) begin
            ramp_value <= held_value;
            updated    <= upd;
            done_res   <= finished;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> (state == ST_DIV))
    else $error("divider active outside divide state");

  a_tick_starts_div: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> (state == ST_DIV))
    else $error("advancing tick did not start divide");

  a_elapsed_holds: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> (elapsed_count == $past(elapsed_count)))
    else $error("elapsed count moved without an input beat");

  a_op_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (op <= OP_P3))
    else $error("multiplier step out of range");

  a_value_only_on_final: assert property (@(posedge clk) disable iff (rst)
    !$stable(held_value) |-> ($past(state) == ST_FINAL))
    else $error("held value changed outside final step");

endmodule

@@ design/tbr_div.sv @@
module tbr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [16:0]          num,
  input  logic [15:0]          den,
  output tbr_pkg::div_stat_t   stat,
  output logic [FRAC_BITS:0]   quot
);
  import tbr_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [15:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [16:0] rem2;
  logic [16:0] diff;
  logic        ge;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den};
  assign diff = rem2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      // a fraction at or above one clamps to one
      if (num >= {1'b0, den}) begin
        quot <= ONE;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        rem  <= num[15:0];
        quot <= '0;
        cnt  <= CW'(FRAC_BITS);
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      quot <= {quot[FRAC_BITS-1:0], ge};
      rem  <= ge ? diff[15:0] : rem2[15:0];
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ tb/tb_timed_bezier_ramp.sv @@
module tb_timed_bezier_ramp;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  localparam int FRAC = 16;
  localparam logic KIND_TICK = 1'b0;
  localparam logic [1:0] CM_CUBIC = 2'd2;
  localparam logic [2:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_B = 3'd7;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 40;

  class ramp_scoreboard;
    typedef struct {
      logic [31:0] value;
      bit          updated;
      bit          done;
    } ramp_beat_t;

    logic [1:0]         mode;
    logic [15:0]        total;
    logic signed [31:0] pts [4];
    logic [16:0]        elapsed;
    bit                 finished;
    logic signed [31:0] held;
    ramp_beat_t         ramp_beats_due[$];
    int                 errors;

    function new();
      mode = CM_LINEAR;
      total = 16'd1;
      foreach (pts[i]) pts[i] = '0;
      elapsed = '0;
      finished = 1'b0;
      held = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_CURVE_MODE:  mode = d[1:0];
        CFG_TOTAL_TICKS: total = d[15:0];
        CFG_POINT_START: pts[0] = d;
        CFG_POINT_MID_A: pts[1] = d;
        CFG_POINT_MID_B: pts[2] = d;
        CFG_POINT_END:   pts[3] = d;
        default: ;
      endcase
    endfunction

    function longint unsigned rnd_q(longint unsigned x);
      return (x + (64'd1 << (FRAC - 1))) >> FRAC;
    endfunction

    function logic signed [31:0] blend_value();
      longint unsigned one, frac_b, frac_a, aa, ab, bb;
      longint unsigned w [4];
      logic [16:0] e;
      longint acc;
      one = 64'd1 << FRAC;
      e = elapsed;
      if (total == 16'd0) begin
        frac_b = one;
      end else begin
        if (e > total) e = {1'b0, total};
        frac_b = (64'(e) << FRAC) / 64'(total);
      end
      frac_a = one - frac_b;
      aa = rnd_q(frac_a * frac_a);
      ab = rnd_q(frac_a * frac_b);
      bb = rnd_q(frac_b * frac_b);
      case (mode)
        CM_LINEAR: w = '{frac_a, 64'd0, 64'd0, frac_b};
        CM_QUAD:   w = '{aa, 2 * ab, 64'd0, bb};
        default:   w = '{rnd_q(aa * frac_a), 3 * rnd_q(aa * frac_b),
                         3 * rnd_q(ab * frac_b), rnd_q(bb * frac_b)};
      endcase
      acc = 0;
      for (int i = 0; i < 4; i++) acc += longint'(pts[i]) * longint'(w[i]);
      acc = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (acc > S32_MAX) acc = S32_MAX;
      if (acc < S32_MIN) acc = S32_MIN;
      return acc[31:0];
    endfunction

    function void note_event(logic k, logic f);
      ramp_beat_t beat;
      beat.updated = 1'b0;
      if (k == KIND_RESTART) begin
        elapsed = '0;
        finished = 1'b0;
      end else if (!finished && !f) begin
        if (elapsed != ELAPSED_MAX) elapsed++;
        held = blend_value();
        beat.updated = 1'b1;
        if (elapsed > total) finished = 1'b1;
      end
      beat.value = held;
      beat.done = finished;
      ramp_beats_due.insert(ramp_beats_due.size(), beat);
    endfunction

    function void check_beat(logic [31:0] v, logic u, logic d);
      ramp_beat_t beat;
      if (ramp_beats_due.size() == 0) begin
        $error("output beat with no event pending: value %h", v);
        errors++;
        return;
      end
      beat = ramp_beats_due.pop_front();
      if (v !== beat.value) begin
        $error("ramp_value mismatch: expected %h, got %h", beat.value, v);
        errors++;
      end
      if (u !== beat.updated) begin
        $error("updated mismatch: expected %0b, got %0b", beat.updated, u);
        errors++;
      end
      if (d !== beat.done) begin
        $error("done_res mismatch: expected %0b, got %0b", beat.done, d);
        errors++;
      end
    endfunction

    function int pending();
      return ramp_beats_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic               frozen;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] ramp_value;
  logic               updated;
  logic               done_res;

  ramp_scoreboard sb;
  bit             idle_on;

  timed_bezier_ramp #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .frozen     (frozen),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ramp_value (ramp_value),
    .updated    (updated),
    .done_res   (done_res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_event(kind, frozen);
    if (!rst && out_valid && !out_stall) sb.check_beat(ramp_value, updated, done_res);
  end

  // Receiver: random stall bursts while idling is enabled
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic load_config(input logic [31:0] m, input logic [31:0] t,
                             input logic [31:0] p0, input logic [31:0] p1,
                             input logic [31:0] p2, input logic [31:0] p3,
                             input bit spare);
    write_cfg(CFG_CURVE_MODE, m);
    write_cfg(CFG_TOTAL_TICKS, t);
    write_cfg(CFG_POINT_START, p0);
    write_cfg(CFG_POINT_MID_A, p1);
    write_cfg(CFG_POINT_MID_B, p2);
    write_cfg(CFG_POINT_END, p3);
    if (spare) begin
      write_cfg(CFG_IDX_SPARE_A, $urandom());
      write_cfg(CFG_IDX_SPARE_B, $urandom());
    end
    cfg_write <= 1'b0;
  endtask

  // Leaves in_valid high after the accepting edge
  task automatic send_item(input logic k, input logic f);
    in_valid <= 1'b1;
    kind     <= k;
    frozen   <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic next_gap(input bit drain);
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (sb.pending() != 0) @(posedge clk);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // T tick, F frozen tick, R restart, Q restart with frozen set
  task automatic play(input string s);
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "F":     send_item(KIND_TICK, 1'b1);
        "R":     send_item(KIND_RESTART, 1'b0);
        "Q":     send_item(KIND_RESTART, 1'b1);
        default: send_item(KIND_TICK, 1'b0);
      endcase
      if (i != s.len() - 1) next_gap(1'b0);
    end
    quiesce();
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] t;
    int sel;
    t = $urandom();
    sel = $urandom_range(0, 9);
    if (sel < 6)       t[15:0] = 16'($urandom_range(1, 24));
    else if (sel == 6) t[15:0] = 16'd0;
    else if (sel == 7) t[15:0] = 16'hFFFF;
    else if (sel == 8) t[15:0] = 16'd1;
    load_config($urandom(), t, pick_point(), pick_point(), pick_point(), pick_point(),
                $urandom_range(0, 3) == 0);
  endtask

  task automatic random_phase(input int ph);
    int r;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)       send_item(KIND_RESTART, 1'($urandom_range(0, 1)));
      else if (r < 20) send_item(KIND_TICK, 1'b1);
      else             send_item(KIND_TICK, 1'b0);
      if (i != PHASE_ITEMS - 1) next_gap(ph == 3 && i == PHASE_ITEMS / 2);
    end
    quiesce();
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    kind      <= KIND_TICK;
    frozen    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // linear, full-scale span, with frozen tick, done and restart
    load_config(32'hFFFF_FFFC, 32'h0000_0004, 32'h8000_0000, 32'h1234_5678,
                32'hDEAD_BEEF, 32'h7FFF_FFFF, 1'b0);
    play("TFTTTTTQT");
    // mode three as cubic, zero total, masked writes, ignored indexes
    load_config(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    play("TTRT");
    load_config(CM_QUAD, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                32'h8000_0000, 1'b0);
    play("TTTTFT");
    load_config(CM_CUBIC, 32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    play("TTQT");

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = !(ph == 5 || ph >= RANDOM_PHASES - 2);
      random_config();
      random_phase(ph);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
